### hdl/sbe_pkg.sv
// shared constants, codes and types of the sensor button event encoder
package sbe_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int WINDOW      = 32;
    localparam int WIN_LOG     = $clog2(WINDOW);
    localparam int SUM_BITS    = SAMPLE_BITS + WIN_LOG;
    localparam int VAL_BITS    = SAMPLE_BITS + 1;
    localparam int MAX_BYTES   = 6;
    localparam int CNT_BITS    = $clog2(MAX_BYTES + 1);
    localparam int TICK_BITS   = 16;

    localparam logic [TICK_BITS-1:0] LONG_TICKS_RESET = 16'd300;
    localparam logic [VAL_BITS-1:0]  LAST_SENT_RESET  = VAL_BITS'(127);
    localparam logic [VAL_BITS-1:0]  VALUE_OFFSET     = VAL_BITS'(20);

    localparam logic [7:0] CODE_ONE_HI     = 8'h10;
    localparam logic [7:0] CODE_ONE_LO     = 8'h20;
    localparam logic [7:0] CODE_TWO_HI     = 8'h50;
    localparam logic [7:0] CODE_TWO_LO     = 8'h60;
    localparam logic [7:0] CODE_B1_PRESS   = 8'h40;
    localparam logic [7:0] CODE_B1_RELEASE = 8'h41;
    localparam logic [7:0] CODE_B1_STARTUP = 8'h42;
    localparam logic [7:0] CODE_B1_LONG    = 8'h43;
    localparam logic [7:0] CODE_B2_PRESS   = 8'h70;
    localparam logic [7:0] CODE_B2_RELEASE = 8'h71;

    typedef struct packed {
        logic                valid;
        logic                full;
        logic                button_one;
        logic                button_two;
        logic [SUM_BITS-1:0] sum_one;
        logic [SUM_BITS-1:0] sum_two;
    } t_win_item;

endpackage

### hdl/sbe_if.sv
// item channel interfaces: sample input, byte output, configuration write
interface sbe_in_if;
    import sbe_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_one;
    logic [SAMPLE_BITS-1:0] sample_two;
    logic                   button_one_level;
    logic                   button_two_level;
    modport source (output valid, sample_one, sample_two, button_one_level,
                    button_two_level, input ready);
    modport sink (input valid, sample_one, sample_two, button_one_level,
                  button_two_level, output ready);
endinterface

interface sbe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       last_of_tick;
    modport source (output valid, message_byte, last_of_tick, input ready);
    modport sink (input valid, message_byte, last_of_tick, output ready);
endinterface

interface sbe_cfg_if;
    import sbe_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [TICK_BITS-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### hdl/sensor_button_event_encoder.sv
// top level: sample window, event encoder and configuration register
// each tick passes the window stages, then is loaded into the byte queue
// throughput: one tick per cycle when it sends nothing, else the next tick
// waits for the byte queue, draining one byte per cycle while output is ready
// reset clears control state and sets the long press limit to 300 ticks
// the 32-entry sample ring is not cleared; its data is only used once written
module sensor_button_event_encoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sbe_in_if.sink    i_item,
    sbe_out_if.source o_item,
    sbe_cfg_if.sink   i_cfg
);
    import sbe_pkg::*;

    logic [TICK_BITS-1:0] r_long_ticks;
    t_win_item            win;
    logic                 adv;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks <= LONG_TICKS_RESET;
        end else if (i_cfg.valid) begin
            r_long_ticks <= i_cfg.data;
        end
    end

    sbe_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_win   (win),
        .i_adv   (adv)
    );

    sbe_event u_event (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_win        (win),
        .o_adv        (adv),
        .i_long_ticks (r_long_ticks),
        .o_item       (o_item)
    );
endmodule

### hdl/sbe_ram.sv
// generic single-port-write ram with registered read
module sbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

### hdl/sbe_window.sv
// sample ring and running window sums, two pipeline stages
module sbe_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sbe_in_if.sink            i_item,
    output sbe_pkg::t_win_item o_win,
    input  logic              i_adv
);
    import sbe_pkg::*;

    logic [WIN_LOG-1:0]     r_wr_idx;
    logic                   r_full;
    logic                   r_s1_vld;
    logic [SAMPLE_BITS-1:0] r_s1_one;
    logic [SAMPLE_BITS-1:0] r_s1_two;
    logic                   r_s1_b1;
    logic                   r_s1_b2;
    logic                   r_s1_sub;
    logic                   r_s1_out;
    logic [WIN_LOG-1:0]     r_s1_idx;
    logic [SUM_BITS-1:0]    r_sum_one;
    logic [SUM_BITS-1:0]    r_sum_two;
    logic                   r_s2_vld;
    logic                   r_s2_out;
    logic                   r_s2_b1;
    logic                   r_s2_b2;

    logic                       accept;
    logic                       s1_adv;
    logic                       item_full;
    logic [2*SAMPLE_BITS-1:0]   rd_data;
    logic [SAMPLE_BITS-1:0]     old_one;
    logic [SAMPLE_BITS-1:0]     old_two;
    logic [SUM_BITS-1:0]        n_sum_one;
    logic [SUM_BITS-1:0]        n_sum_two;

    assign s1_adv       = r_s1_vld && (!r_s2_vld || i_adv);
    assign i_item.ready = !r_s1_vld || s1_adv;
    assign accept       = i_item.valid && i_item.ready;
    assign item_full    = r_full || (r_wr_idx == WIN_LOG'(WINDOW - 1));

    sbe_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_idx),
        .i_wr_data ({r_s1_one, r_s1_two}),
        .i_rd_en   (accept),
        .i_rd_addr (r_wr_idx),
        .o_rd_data (rd_data)
    );

    // entries not yet written subtract nothing from the sum
    assign old_one = r_s1_sub ? rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
    assign old_two = r_s1_sub ? rd_data[SAMPLE_BITS-1:0] : '0;
    assign n_sum_one = r_sum_one - SUM_BITS'(old_one) + SUM_BITS'(r_s1_one);
    assign n_sum_two = r_sum_two - SUM_BITS'(old_two) + SUM_BITS'(r_s1_two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx  <= '0;
            r_full    <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_sum_one <= '0;
            r_sum_two <= '0;
        end else begin
            if (accept) begin
                r_wr_idx <= r_wr_idx + WIN_LOG'(1);
                r_full   <= item_full;
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_vld  <= 1'b1;
                r_sum_one <= n_sum_one;
                r_sum_two <= n_sum_two;
            end else if (i_adv) begin
                r_s2_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_one <= i_item.sample_one;
            r_s1_two <= i_item.sample_two;
            r_s1_b1  <= i_item.button_one_level;
            r_s1_b2  <= i_item.button_two_level;
            r_s1_sub <= r_full;
            r_s1_out <= item_full;
            r_s1_idx <= r_wr_idx;
        end
        if (s1_adv) begin
            r_s2_out <= r_s1_out;
            r_s2_b1  <= r_s1_b1;
            r_s2_b2  <= r_s1_b2;
        end
    end

    always_comb begin
        o_win.valid      = r_s2_vld;
        o_win.full       = r_s2_out;
        o_win.button_one = r_s2_b1;
        o_win.button_two = r_s2_b2;
        o_win.sum_one    = r_sum_one;
        o_win.sum_two    = r_sum_two;
    end
endmodule

### hdl/sbe_event.sv
// change detection, button events and byte queue towards the output
module sbe_event (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sbe_pkg::t_win_item              i_win,
    output logic                            o_adv,
    input  logic [sbe_pkg::TICK_BITS-1:0]   i_long_ticks,
    sbe_out_if.source                       o_item
);
    import sbe_pkg::*;

    localparam logic [1:0] MODE_STARTUP      = 2'd0;
    localparam logic [1:0] MODE_STARTUP_HELD = 2'd1;
    localparam logic [1:0] MODE_LAST_LOW     = 2'd2;
    localparam logic [1:0] MODE_LAST_HIGH    = 2'd3;

    logic [7:0]           r_buf [MAX_BYTES];
    logic [CNT_BITS-1:0]  r_cnt;
    logic [VAL_BITS-1:0]  r_last_one;
    logic [VAL_BITS-1:0]  r_last_two;
    logic [1:0]           r_mode;
    logic [TICK_BITS-1:0] r_hold;
    logic                 r_long;
    logic                 r_b2_last;

    logic [1:0]           n_mode;
    logic [TICK_BITS-1:0] n_hold;
    logic                 n_long;

    logic                   take;
    logic                   step;
    logic                   upd;
    logic [SAMPLE_BITS-1:0] avg_one;
    logic [SAMPLE_BITS-1:0] avg_two;
    logic [VAL_BITS-1:0]    v_one;
    logic [VAL_BITS-1:0]    v_two;
    logic [SAMPLE_BITS-3:0] q_one;
    logic [SAMPLE_BITS-3:0] q_two;
    logic                   send_one;
    logic                   send_two;
    logic                   pressed;
    logic                   b1_emit;
    logic [7:0]             b1_byte;
    logic                   b2_emit;
    logic [7:0]             cand [MAX_BYTES];
    logic                   cand_en [MAX_BYTES];
    logic [7:0]             lst [MAX_BYTES];
    logic [CNT_BITS-1:0]    num;

    function automatic logic changed(input logic [VAL_BITS-1:0] v,
                                     input logic [VAL_BITS-1:0] old,
                                     input logic coarse);
        logic near;
        near = ({1'b0, old} <= {1'b0, v} + (VAL_BITS + 1)'(1))
            && ({1'b0, old} + (VAL_BITS + 1)'(1) >= {1'b0, v});
        return !near && !(coarse && (v[VAL_BITS-1:2] == old[VAL_BITS-1:2]));
    endfunction

    assign take  = o_item.valid && o_item.ready;
    assign o_adv = (r_cnt == '0) || ((r_cnt == CNT_BITS'(1)) && take);
    assign step  = i_win.valid && o_adv;
    assign upd   = step && i_win.full;

    assign avg_one  = SAMPLE_BITS'(i_win.sum_one >> WIN_LOG);
    assign avg_two  = SAMPLE_BITS'(i_win.sum_two >> WIN_LOG);
    assign v_one    = {1'b0, avg_one} + VALUE_OFFSET;
    assign v_two    = {1'b0, avg_two} + VALUE_OFFSET;
    assign q_one    = avg_one[SAMPLE_BITS-1:2];
    assign q_two    = avg_two[SAMPLE_BITS-1:2];
    assign send_one = changed(v_one, r_last_one, 1'b1);
    assign send_two = changed(v_two, r_last_two, 1'b0);
    assign pressed  = !i_win.button_one;
    assign b2_emit  = i_win.button_two != r_b2_last;

    always_comb begin
        logic [TICK_BITS-1:0] hc;
        hc      = (pressed && (r_hold != '1)) ? r_hold + TICK_BITS'(1) : r_hold;
        n_mode  = r_mode;
        n_hold  = hc;
        n_long  = r_long;
        b1_emit = 1'b0;
        b1_byte = CODE_B1_LONG;
        if (pressed && (hc > i_long_ticks)) begin
            if (!r_long) begin
                n_long  = 1'b1;
                b1_emit = 1'b1;
            end
        end else begin
            case (r_mode)
                MODE_STARTUP: begin
                    if (pressed) begin
                        n_mode  = MODE_STARTUP_HELD;
                        b1_emit = 1'b1;
                        b1_byte = CODE_B1_STARTUP;
                    end else begin
                        n_mode = MODE_LAST_HIGH;
                        n_hold = '0;
                        n_long = 1'b0;
                    end
                end
                MODE_STARTUP_HELD: begin
                    if (!pressed) begin
                        n_mode = MODE_LAST_HIGH;
                        n_hold = '0;
                        n_long = 1'b0;
                    end
                end
                default: begin
                    if ((r_mode == MODE_LAST_HIGH) != i_win.button_one) begin
                        n_mode = i_win.button_one ? MODE_LAST_HIGH : MODE_LAST_LOW;
                        n_hold = '0;
                        if (r_long) begin
                            n_long = 1'b0;
                        end else begin
                            b1_emit = 1'b1;
                            b1_byte = i_win.button_one ? CODE_B1_RELEASE : CODE_B1_PRESS;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        cand[0]    = CODE_ONE_HI | {4'h0, 4'(q_one >> 4)};
        cand[1]    = CODE_ONE_LO | {4'h0, 4'(q_one)};
        cand[2]    = CODE_TWO_HI | {4'h0, 4'(q_two >> 4)};
        cand[3]    = CODE_TWO_LO | {4'h0, 4'(q_two)};
        cand[4]    = b1_byte;
        cand[5]    = i_win.button_two ? CODE_B2_RELEASE : CODE_B2_PRESS;
        cand_en[0] = send_one;
        cand_en[1] = send_one;
        cand_en[2] = send_two;
        cand_en[3] = send_two;
        cand_en[4] = b1_emit;
        cand_en[5] = b2_emit;
        num        = '0;
        for (int i = 0; i < MAX_BYTES; i++) begin
            lst[i] = '0;
        end
        for (int i = 0; i < MAX_BYTES; i++) begin
            if (cand_en[i]) begin
                lst[num] = cand[i];
                num      = num + CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_last_one <= LAST_SENT_RESET;
            r_last_two <= LAST_SENT_RESET;
            r_mode     <= MODE_STARTUP;
            r_hold     <= '0;
            r_long     <= 1'b0;
            r_b2_last  <= 1'b0;
        end else begin
            if (step) begin
                r_cnt <= i_win.full ? num : '0;
            end else if (take) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
            end
            if (upd) begin
                if (send_one) begin
                    r_last_one <= v_one;
                end
                if (send_two) begin
                    r_last_two <= v_two;
                end
                r_mode    <= n_mode;
                r_hold    <= n_hold;
                r_long    <= n_long;
                r_b2_last <= i_win.button_two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_buf <= lst;
        end else if (take) begin
            for (int i = 0; i < MAX_BYTES - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

    assign o_item.valid        = r_cnt != '0;
    assign o_item.message_byte = r_buf[0];
    assign o_item.last_of_tick = r_cnt == CNT_BITS'(1);
endmodule
